// ----- src/wrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wrm_pkg: shared definitions for the wildcard regex matcher
// Sizes, command and error codes, special pattern bytes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wrm_pkg;

  // pattern capacity and derived widths
  localparam int MAX_PATTERN = 32;
  localparam int ROW_W       = MAX_PATTERN + 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W      = $clog2(MAX_PATTERN);

  // field widths
  localparam int CMD_W = 2;
  localparam int SYM_W = 8;
  localparam int ERR_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NEW     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_AFTER_TXT = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LEAD_STAR = 2'd3;

  // special pattern bytes
  localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [SYM_W-1:0] DOT_BYTE  = 8'h2E;

  // controller to datapath
  typedef struct packed {
    logic do_clear;
    logic do_append;
    logic do_restart;
    logic text_start;
    logic text_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_zero;
    logic step_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/wrm_if.sv -----
// ----------------------------------------------------------------------------
// wrm_if: valid/ready channels of the wildcard regex matcher
// One interface for the input words and one for the result words.
// ----------------------------------------------------------------------------
interface wrm_in_if;
  import wrm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SYM_W-1:0] symbol;
  logic             text_last;

  modport source (output valid, cmd, symbol, text_last, input ready);
  modport sink   (input valid, cmd, symbol, text_last, output ready);
endinterface

interface wrm_out_if;
  import wrm_pkg::*;

  logic             valid;
  logic             ready;
  logic             matched;
  logic             is_final;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, matched, is_final, error_code, input ready);
  modport sink   (input valid, matched, is_final, error_code, output ready);
endinterface

// ----- src/wildcard_regex_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_regex_matcher: full-text matcher for '.' and '*' patterns
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each input word is a command: start an empty pattern, append a pattern
// byte, feed a text byte, or restart the text; every word returns exactly one
// result word telling whether the text so far matches the whole pattern,
// plus an end-of-text echo and an error code. Pattern commands and restarts
// go straight to the finish state once accepted; a text byte first steps
// through each position of a nonempty pattern, as the match row is advanced
// one pattern position per cycle through the single read port of the pattern
// memory. A new word is taken once the previous result sits in the output
// register, so a waiting result stalls input only after the next word is
// done. No clearing pass is needed after reset.
module wildcard_regex_matcher (
  input  logic       clk,
  input  logic       rst_n,
  wrm_in_if.sink     in_ch,
  wrm_out_if.source  out_ch
);
  import wrm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  wrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // pattern store, rows and result register
  wrm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .symbol         (in_ch.symbol),
    .text_last      (in_ch.text_last),
    .out_ready      (out_ch.ready),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_matched    (out_ch.matched),
    .out_is_final   (out_ch.is_final),
    .out_error_code (out_ch.error_code)
  );

  // an accepted word is worked on before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while previous word still in progress");

  // end of text only comes from a text byte, which never flags an error
  a_final_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_final) |-> (out_ch.error_code == ERR_OK))
    else $error("final text result carries an error code");

  // a fresh empty pattern always reports a match of the empty text
  a_new_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_NEW) && !out_ch.valid)
    |=> ##1 (out_ch.valid && out_ch.matched))
    else $error("empty pattern did not match the empty text");

endmodule

// ----- src/wrm_dp.sv -----
// ----------------------------------------------------------------------------
// wrm_dp: matcher datapath
// Pattern memory, empty-text row, match row updated one pattern position
// per cycle, and the result register.
// ----------------------------------------------------------------------------
module wrm_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wrm_pkg::dp_cmd_t         cmd,
  input  logic [wrm_pkg::SYM_W-1:0] symbol,
  input  logic                     text_last,
  input  logic                     out_ready,
  output wrm_pkg::dp_stat_t        stat,
  output logic                     out_valid,
  output logic                     out_matched,
  output logic                     out_is_final,
  output logic [wrm_pkg::ERR_W-1:0] out_error_code
);
  import wrm_pkg::*;

  // pattern memory
  logic [SYM_W-1:0]  pat_mem [MAX_PATTERN];
  logic [SYM_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  // control state
  logic [IDX_W-1:0] len_r, len_nxt;
  logic [ROW_W-1:0] etr_r, etr_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;

  // per-item payload
  logic [SYM_W-1:0] char_r, char_nxt;
  logic [SYM_W-1:0] prev_pat_r, prev_pat_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             n1_r, n1_nxt;
  logic             n2_r, n2_nxt;
  logic             mprev_r, mprev_nxt;
  logic             fin_r, fin_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             res_match_r, res_match_nxt;
  logic             res_fin_r, res_fin_nxt;
  logic [ERR_W-1:0] res_err_r, res_err_nxt;

  // append checks
  logic [ERR_W-1:0] app_err;
  logic [IDX_W-1:0] len_inc;
  logic             sym_star;

  // step terms
  logic star_pos;
  logic hit_prev;
  logic hit_cur;
  logic m_cur;
  logic n_cur;

  assign sym_star = (symbol == STAR_BYTE);
  assign len_inc  = len_r + IDX_W'(1);

  always_comb begin
    if (started_r) begin
      app_err = ERR_AFTER_TXT;
    end else if (len_r == IDX_W'(MAX_PATTERN)) begin
      app_err = ERR_FULL;
    end else if (sym_star && (len_r == '0)) begin
      app_err = ERR_LEAD_STAR;
    end else begin
      app_err = ERR_OK;
    end
  end

  // one pattern position of the text-byte update
  assign star_pos = (rd_data_r == STAR_BYTE) && (j_r >= IDX_W'(2));
  assign hit_prev = (prev_pat_r == DOT_BYTE) || (prev_pat_r == char_r);
  assign hit_cur  = (rd_data_r == DOT_BYTE) || (rd_data_r == char_r);
  assign m_cur    = row_r[j_r];
  assign n_cur    = star_pos ? (n2_r | (m_cur & hit_prev)) : (mprev_r & hit_cur);

  assign mem_we  = cmd.do_append && (app_err == ERR_OK);
  assign rd_addr = cmd.text_start ? '0 : j_r[ADDR_W-1:0];

  // next-state logic
  always_comb begin
    len_nxt       = len_r;
    etr_nxt       = etr_r;
    row_nxt       = row_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    prev_pat_nxt  = prev_pat_r;
    j_nxt         = j_r;
    n1_nxt        = n1_r;
    n2_nxt        = n2_r;
    mprev_nxt     = mprev_r;
    fin_nxt       = fin_r;
    err_nxt       = err_r;
    res_match_nxt = res_match_r;
    res_fin_nxt   = res_fin_r;
    res_err_nxt   = res_err_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.do_clear) begin
      len_nxt     = '0;
      etr_nxt     = ROW_W'(1);
      row_nxt     = ROW_W'(1);
      started_nxt = 1'b0;
      fin_nxt     = 1'b0;
      err_nxt     = ERR_OK;
    end else if (cmd.do_append) begin
      fin_nxt = 1'b0;
      err_nxt = app_err;
      if (app_err == ERR_OK) begin
        len_nxt = len_inc;
        // a star copies the bit two positions back, anything else clears
        etr_nxt[len_inc] = sym_star ? etr_r[len_r - IDX_W'(1)] : 1'b0;
        row_nxt = etr_nxt;
      end
    end else if (cmd.do_restart) begin
      row_nxt     = etr_r;
      started_nxt = 1'b0;
      fin_nxt     = 1'b0;
      err_nxt     = ERR_OK;
    end else if (cmd.text_start) begin
      char_nxt    = symbol;
      j_nxt       = IDX_W'(1);
      mprev_nxt   = row_r[0];
      row_nxt[0]  = 1'b0;
      n1_nxt      = 1'b0;
      n2_nxt      = 1'b0;
      started_nxt = 1'b1;
      fin_nxt     = text_last;
      err_nxt     = ERR_OK;
    end else if (cmd.text_step) begin
      // in-place row update, old bit kept for the next position
      row_nxt[j_r] = n_cur;
      mprev_nxt    = m_cur;
      n2_nxt       = n1_r;
      n1_nxt       = n_cur;
      prev_pat_nxt = rd_data_r;
      j_nxt        = j_r + IDX_W'(1);
    end else if (cmd.finish) begin
      res_match_nxt = row_r[len_r];
      res_fin_nxt   = fin_r;
      res_err_nxt   = err_r;
      out_valid_nxt = 1'b1;
      if (fin_r) begin
        row_nxt     = etr_r;
        started_nxt = 1'b0;
      end
    end
  end

  // pattern memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pat_mem[len_r[ADDR_W-1:0]] <= symbol;
    end
    rd_data_r <= pat_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      etr_r       <= ROW_W'(1);
      row_r       <= ROW_W'(1);
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      etr_r       <= etr_nxt;
      row_r       <= row_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    prev_pat_r  <= prev_pat_nxt;
    j_r         <= j_nxt;
    n1_r        <= n1_nxt;
    n2_r        <= n2_nxt;
    mprev_r     <= mprev_nxt;
    fin_r       <= fin_nxt;
    err_r       <= err_nxt;
    res_match_r <= res_match_nxt;
    res_fin_r   <= res_fin_nxt;
    res_err_r   <= res_err_nxt;
  end

  // status back to the controller
  assign stat.len_zero  = (len_r == '0);
  assign stat.step_last = (j_r == len_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_matched    = res_match_r;
  assign out_is_final   = res_fin_r;
  assign out_error_code = res_err_r;

endmodule

// ----- src/wrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrm_ctrl: matcher controller
// Accepts one word at a time, sequences the per-position row update for
// text bytes and hands the result to the output register.
// ----------------------------------------------------------------------------
module wrm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [wrm_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_ready,
  input  wrm_pkg::dp_stat_t         stat,
  output wrm_pkg::dp_cmd_t          cmd
);
  import wrm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode and sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FIN;
          case (in_cmd)
            CMD_NEW:    cmd.do_clear  = 1'b1;
            CMD_APPEND: cmd.do_append = 1'b1;
            CMD_TEXT: begin
              cmd.text_start = 1'b1;
              if (!stat.len_zero) begin
                state_nxt = ST_STEP;
              end
            end
            default:    cmd.do_restart = 1'b1;
          endcase
        end
      end
      ST_STEP: begin
        cmd.text_step = 1'b1;
        if (stat.step_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- tb/sv/match_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// match_scoreboard_pkg: result prediction for the wildcard regex matcher
// Keeps its own pattern, base row and match row. Every accepted input word
// queues the result word the matcher must return. Result words are checked
// field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
package match_scoreboard_pkg;
  import wrm_pkg::*;

  typedef struct packed {
    logic             matched;
    logic             is_final;
    logic [ERR_W-1:0] error_code;
  } match_result_t;

  class match_scoreboard;
    logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
    int unsigned      pattern_len;
    logic [ROW_W-1:0] empty_row;
    logic [ROW_W-1:0] live_row;
    bit               text_open;
    match_result_t    expected_results [$];
    int unsigned      errors;

    function new();
      errors = 0;
      clear_pattern();
    endfunction

    function void restart_text();
      live_row  = empty_row;
      text_open = 1'b0;
    endfunction

    function void clear_pattern();
      foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      pattern_len = 0;
      empty_row   = '0;
      empty_row[0] = 1'b1;
      restart_text();
    endfunction

    // extend the base row by one pattern byte
    function logic [ERR_W-1:0] append_symbol(logic [SYM_W-1:0] b);
      if (text_open) return ERR_AFTER_TXT;
      if (pattern_len >= MAX_PATTERN) return ERR_FULL;
      if (b == STAR_BYTE && pattern_len == 0) return ERR_LEAD_STAR;
      pattern_bytes[pattern_len] = b;
      pattern_len++;
      // a star lets the preceding element vanish for the empty text
      if (b == STAR_BYTE) begin
        empty_row[pattern_len] = empty_row[pattern_len-2];
      end else begin
        empty_row[pattern_len] = 1'b0;
      end
      live_row = empty_row;
      return ERR_OK;
    endfunction

    // advance the match row by one text byte
    function void advance_row(logic [SYM_W-1:0] c);
      logic [ROW_W-1:0] next_row;
      logic [SYM_W-1:0] elem;
      logic             hit;
      next_row = '0;
      for (int j = 1; j <= int'(pattern_len); j++) begin
        if (pattern_bytes[j-1] == STAR_BYTE && j >= 2) begin
          elem = pattern_bytes[j-2];
          hit  = (elem == DOT_BYTE) || (elem == c);
          next_row[j] = next_row[j-2] | (live_row[j] & hit);
        end else begin
          elem = pattern_bytes[j-1];
          hit  = (elem == DOT_BYTE) || (elem == c);
          next_row[j] = live_row[j-1] & hit;
        end
      end
      live_row  = next_row;
      text_open = 1'b1;
    endfunction

    // accepted input word: queue the result it must produce
    function void note_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] symbol, logic last);
      match_result_t want;
      want = '0;
      case (cmd)
        CMD_NEW: clear_pattern();
        CMD_APPEND: want.error_code = append_symbol(symbol);
        CMD_TEXT: begin
          advance_row(symbol);
          want.is_final = last;
        end
        default: restart_text();
      endcase
      want.matched = live_row[pattern_len];
      // end of text: next byte begins a new text
      if (cmd == CMD_TEXT && last) restart_text();
      expected_results.push_back(want);
    endfunction

    // accepted result word: compare with the oldest expectation
    function void check_result(logic matched, logic is_final, logic [ERR_W-1:0] error_code);
      match_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: matched=%0b is_final=%0b error_code=%0d",
                 $time, matched, is_final, error_code);
        return;
      end
      want = expected_results.pop_front();
      if (matched !== want.matched) begin
        errors++;
        $display("%0t: matched: expected %0b, actual %0b", $time, want.matched, matched);
      end
      if (is_final !== want.is_final) begin
        errors++;
        $display("%0t: is_final: expected %0b, actual %0b", $time, want.is_final, is_final);
      end
      if (error_code !== want.error_code) begin
        errors++;
        $display("%0t: error_code: expected %0d, actual %0d", $time, want.error_code,
                 error_code);
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the wildcard regex matcher
// A directed opening covers empty patterns, leading and repeated stars,
// appends after text, end of text and restarts. Random groups follow: a
// new pattern of random length (a few past capacity), then texts built to
// fit the pattern or drawn at random, with noise words mixed in. Both
// channels idle at random and every result word is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import wrm_pkg::*;
  import match_scoreboard_pkg::*;

  localparam int TOTAL_WORDS = 1500;

  logic clk;
  logic rst_n;

  wrm_in_if  in_ch ();
  wrm_out_if out_ch ();

  wildcard_regex_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  match_scoreboard sb;
  int unsigned     words_sent;
  bit              quiet_phase;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // idle length: mostly none or short, a few long, none in quiet phases
  function automatic int idle_cycles();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SYM_W-1:0] text_symbol();
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [SYM_W-1:0] pattern_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return DOT_BYTE;
    if (r < 45) return STAR_BYTE;
    if (r < 92) return 8'h61 + 8'($urandom_range(0, 2));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.cmd, in_ch.symbol, in_ch.text_last);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.matched, out_ch.is_final, out_ch.error_code);
    end
  end

  // result side: random stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one input word, returns at the accepting edge with valid still high
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] symbol, logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.symbol    <= symbol;
    in_ch.text_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // hold off input until every result word is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    send_word(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // new pattern, keeping a copy of the bytes the matcher will keep
  task automatic load_pattern(int n, ref logic [SYM_W-1:0] kept [$]);
    logic [SYM_W-1:0] b;
    kept.delete();
    send_word(CMD_NEW, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (n) begin
      b = pattern_symbol();
      send_word(CMD_APPEND, b, 1'($urandom_range(0, 1)));
      if (kept.size() < MAX_PATTERN && !(b == STAR_BYTE && kept.size() == 0))
        kept.push_back(b);
    end
  endtask

  // one text, either shaped after the pattern or random
  task automatic send_text(logic [SYM_W-1:0] kept [$]);
    logic [SYM_W-1:0] txt [$];
    logic [SYM_W-1:0] elem;
    int i;
    int reps;
    if ($urandom_range(0, 2) != 0) begin
      // walk the pattern: starred elements 0..3 times, dots any byte
      i = 0;
      while (i < kept.size()) begin
        elem = kept[i];
        reps = 1;
        if (i + 1 < kept.size() && kept[i+1] == STAR_BYTE) begin
          reps = $urandom_range(0, 3);
          i++;
        end
        repeat (reps) txt.push_back(elem == DOT_BYTE ? text_symbol() : elem);
        i++;
      end
      // occasional corruption
      if (txt.size() > 0 && $urandom_range(0, 3) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = text_symbol();
    end else begin
      repeat ($urandom_range(0, 8)) txt.push_back(text_symbol());
    end
    if (txt.size() == 0) begin
      send_word(CMD_RESTART, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    foreach (txt[k]) begin
      if (k == txt.size() - 1) begin
        // end the text by its flag, or now and then by a restart
        if ($urandom_range(0, 7) == 0) begin
          send_word(CMD_TEXT, txt[k], 1'b0);
          send_word(CMD_RESTART, SYM_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end else begin
          send_word(CMD_TEXT, txt[k], 1'b1);
        end
      end else begin
        send_word(CMD_TEXT, txt[k], 1'b0);
        // pattern byte in the middle of a text
        if ($urandom_range(0, 14) == 0)
          send_word(CMD_APPEND, pattern_symbol(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_directed();
    send_word(CMD_NEW, 8'h00, 1'b0);
    send_word(CMD_APPEND, STAR_BYTE, 1'b0);     // leading star
    send_word(CMD_TEXT, 8'h00, 1'b1);           // text against empty pattern
    send_word(CMD_RESTART, 8'h00, 1'b0);
    send_word(CMD_APPEND, 8'hFF, 1'b1);
    send_word(CMD_APPEND, STAR_BYTE, 1'b0);
    send_word(CMD_APPEND, STAR_BYTE, 1'b0);     // star after star
    send_word(CMD_APPEND, DOT_BYTE, 1'b0);
    send_word(CMD_TEXT, 8'hFF, 1'b0);
    send_word(CMD_APPEND, "x", 1'b0);           // pattern byte after text began
    send_word(CMD_TEXT, STAR_BYTE, 1'b0);
    send_word(CMD_TEXT, 8'h00, 1'b1);
    send_word(CMD_TEXT, 8'hFF, 1'b0);
    send_word(CMD_RESTART, 8'hFF, 1'b1);
    send_word(CMD_APPEND, "q", 1'b0);
    send_word(CMD_TEXT, 8'hFF, 1'b1);
    send_word(CMD_TEXT, "q", 1'b1);
    send_word(CMD_NEW, 8'hFF, 1'b1);
    send_word(CMD_TEXT, 8'h55, 1'b0);
    send_word(CMD_RESTART, 8'h55, 1'b1);
  endtask

  // stimulus and end of run
  initial begin
    logic [SYM_W-1:0] kept [$];
    int r;
    int n;
    int groups;
    sb          = new();
    words_sent  = 0;
    groups      = 0;
    quiet_phase = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_NEW;
    in_ch.symbol    <= '0;
    in_ch.text_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_for_results();

    while (words_sent < TOTAL_WORDS) begin
      quiet_phase = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) n = $urandom_range(0, 6);
      else if (r < 93) n = $urandom_range(7, 31);
      else n = $urandom_range(32, 35);
      load_pattern(n, kept);
      repeat ($urandom_range(1, 4)) send_text(kept);
      if ($urandom_range(0, 9) == 0) send_noise();
      groups++;
      if (groups % 40 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (100) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d result words never arrived", $time, sb.expected_results.size());
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
